FILE: hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types, sizes and helpers of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int OUT_BITS    = SAMPLE_BITS + 1;
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int CFG_BITS    = 7;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [OUT_BITS-1:0]    t_result;
    typedef logic [CNT_BITS-1:0]           t_count;

    // one slot of the sorted chain: sample plus its age in items
    typedef struct packed {
        logic                   valid;
        logic [IDX_BITS-1:0]    age;
        t_sample                value;
    } t_entry;

    // operation applied to all cells in the same cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLR,
        OP_DEL,
        OP_INS,
        OP_ROT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_sample x;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // window size register mapped into 1 .. WINDOW_MAX
    function automatic t_count eff_window(input logic [CFG_BITS-1:0] w);
        t_count r;
        if (w == '0) begin
            r = t_count'(1);
        end else if (int'(w) > WINDOW_MAX) begin
            r = t_count'(WINDOW_MAX);
        end else begin
            r = t_count'(w);
        end
        return r;
    endfunction

endpackage

FILE: hdl/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// Median over the last window_size samples, given doubled so that even
// windows stay exact. Samples sit in a chain of cells kept in sorted order.
//
//   channel  direction  handshake                   payload
//   in       to block   i_valid / o_stall           i_sample, i_restart
//   out      from block o_valid / i_stall           o_median_doubled
//   cfg      to block   i_cfg_valid / o_cfg_ready   i_cfg_data (window_size)
//
// An item goes through accept, delete and insert when the window is not yet
// full; when it gives a result it then goes through the median scan, which rotates the
// whole 64 cell chain once past the rank counter at its head, and then the
// done state loads the output register.
// Reset is synchronous; it empties the chain and sets window_size to 1.
// o_stall is high while an item is in work; a finished result waits in the
// output register and the next item is accepted meanwhile. A new result
// holds in the done state while the previous one is still stalled.
// ----------------------------------------------------------------------------
module sliding_window_median (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  swm_pkg::t_sample                 i_sample,
    input  logic                             i_restart,
    output logic                             o_valid,
    input  logic                             i_stall,
    output swm_pkg::t_result                 o_median_doubled,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]     i_cfg_data
);
    import swm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                 r_state;
    t_sample                r_x;
    t_count                 r_fill;
    logic [IDX_BITS-1:0]    r_scan;
    logic [CFG_BITS-1:0]    r_wsize;
    logic                   r_out_valid;
    t_result                r_out_data;

    t_cell_ctl              w_ctl;
    t_scan_ctl              w_scan_ctl;
    t_count                 w_weff;
    t_count                 w_fill_inc;
    t_result                w_median;
    logic                   w_accept;

    t_entry                 w_entry [WINDOW_MAX];
    t_entry                 w_left  [WINDOW_MAX];
    t_entry                 w_right [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  w_gt;
    logic [WINDOW_MAX-1:0]  w_left_gt;
    logic [WINDOW_MAX-1:0]  w_shift;
    logic [WINDOW_MAX-1:0]  w_hit;
    logic [WINDOW_MAX-1:0]  w_valid;
    logic [IDX_BITS-1:0]    w_del_enc;
    t_count                 w_del_idx;

    assign o_stall          = (r_state != S_IDLE);
    assign w_accept         = i_valid && !o_stall;
    assign o_valid          = r_out_valid;
    assign o_median_doubled = r_out_data;
    assign o_cfg_ready      = 1'b1;
    assign w_weff           = eff_window(r_wsize);
    assign w_fill_inc       = (r_fill == t_count'(WINDOW_MAX)) ? r_fill : r_fill + 1'b1;

    // neighbor wiring; the tail closes the ring only while rotating
    always_comb begin
        w_left[0]    = '0;
        w_left_gt[0] = 1'b0;
        for (int i = 1; i < WINDOW_MAX; i++) begin
            w_left[i]    = w_entry[i-1];
            w_left_gt[i] = w_gt[i-1];
        end
        for (int i = 0; i < WINDOW_MAX - 1; i++) begin
            w_right[i] = w_entry[i+1];
        end
        w_right[WINDOW_MAX-1] = (w_ctl.op == OP_ROT) ? w_entry[0] : t_entry'('0);
    end

    // locate the sample that leaves the full window
    always_comb begin
        w_del_enc = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_valid[i] = w_entry[i].valid;
            w_hit[i]   = w_entry[i].valid && (w_entry[i].age == IDX_BITS'(WINDOW_MAX - 1));
            if (w_hit[i]) begin
                w_del_enc = w_del_enc | IDX_BITS'(i);
            end
        end
        w_del_idx = (|w_hit) ? t_count'(w_del_enc) : t_count'(WINDOW_MAX);
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_shift[i] = (w_del_idx <= t_count'(i));
        end
    end

    // cell operation and scan control per state
    always_comb begin
        w_ctl.x         = r_x;
        w_ctl.op        = OP_HOLD;
        w_scan_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_restart) begin
                    w_ctl.op = OP_CLR;
                end
            end
            S_DEL: begin
                w_ctl.op = OP_DEL;
            end
            S_INS: begin
                w_ctl.op         = OP_INS;
                w_scan_ctl.clear = 1'b1;
            end
            S_SCAN: begin
                w_ctl.op        = OP_ROT;
                w_scan_ctl.step = 1'b1;
            end
            default: begin
                w_ctl.op = OP_HOLD;
            end
        endcase
    end

    // sorted chain of cells
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        swm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_left    (w_left[gi]),
            .i_right   (w_right[gi]),
            .i_left_gt (w_left_gt[gi]),
            .i_shift   (w_shift[gi]),
            .o_entry   (w_entry[gi]),
            .o_gt      (w_gt[gi])
        );
    end

    // rank selection at the chain head
    swm_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_scan_ctl),
        .i_weff   (w_weff),
        .i_head   (w_entry[0]),
        .o_median (w_median)
    );

    // sequencer, window register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_scan      <= '0;
            r_wsize     <= CFG_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wsize <= i_cfg_data;
            end
            // the done state reloads the output register itself
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x     <= i_sample;
                        r_state <= S_DEL;
                        if (i_restart) begin
                            r_fill <= '0;
                        end
                    end
                end
                S_DEL: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_fill <= w_fill_inc;
                    r_scan <= '0;
                    if (w_fill_inc >= w_weff) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == IDX_BITS'(WINDOW_MAX - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= w_median;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ages of held samples are distinct, so at most one leaves
    a_one_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matches the oldest age");

    // between items the chain holds exactly the counted samples
    a_fill_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_valid) == int'(r_fill)))
        else $error("valid cells disagree with fill count");

    // a result only appears after a finished scan
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

endmodule

FILE: hdl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted sample chain. Clears, and deletes, inserts and rotates by
// taking data from its left or right neighbor.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swm_pkg::t_cell_ctl i_ctl,
    input  swm_pkg::t_entry    i_left,
    input  swm_pkg::t_entry    i_right,
    input  logic               i_left_gt,
    input  logic               i_shift,
    output swm_pkg::t_entry    o_entry,
    output logic               o_gt
);
    import swm_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // empty slots sort after every sample
    assign o_gt    = !r_entry.valid || (r_entry.value > i_ctl.x);
    assign o_entry = r_entry;

    // next slot content
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_HOLD: begin
                n_entry = r_entry;
            end
            OP_CLR: begin
                n_entry.valid = 1'b0;
            end
            OP_DEL: begin
                if (i_shift) begin
                    n_entry = i_right;
                end
            end
            OP_INS: begin
                if (o_gt) begin
                    if (i_left_gt) begin
                        n_entry     = i_left;
                        n_entry.age = i_left.age + 1'b1;
                    end else begin
                        n_entry.valid = 1'b1;
                        n_entry.age   = '0;
                        n_entry.value = i_ctl.x;
                    end
                end else begin
                    n_entry.age = r_entry.age + 1'b1;
                end
            end
            OP_ROT: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // slot register, only the valid flag is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

FILE: hdl/swm_select.sv
// ----------------------------------------------------------------------------
// swm_select
// Rank counter at the head of the rotating chain. Picks the two middle
// samples of the window (the same one for an odd window) and forms their sum.
// ----------------------------------------------------------------------------
module swm_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swm_pkg::t_scan_ctl i_ctl,
    input  swm_pkg::t_count    i_weff,
    input  swm_pkg::t_entry    i_head,
    output swm_pkg::t_result   o_median
);
    import swm_pkg::*;

    t_count  r_rank;
    t_sample r_lo;
    t_sample r_hi;
    t_count  w_k_lo;
    t_count  w_k_hi;
    logic    w_match;

    // ranks of the lower and upper middle samples
    assign w_k_lo  = (i_weff - 1'b1) >> 1;
    assign w_k_hi  = i_weff >> 1;
    assign w_match = i_head.valid && ({1'b0, i_head.age} < i_weff);

    // count window members passing the head in sorted order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else if (i_ctl.clear) begin
            r_rank <= '0;
        end else if (i_ctl.step && w_match) begin
            r_rank <= r_rank + 1'b1;
        end
    end

    // capture the middle samples
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && w_match) begin
            if (r_rank == w_k_lo) begin
                r_lo <= i_head.value;
            end
            if (r_rank == w_k_hi) begin
                r_hi <= i_head.value;
            end
        end
    end

    assign o_median = {r_lo[SAMPLE_BITS-1], r_lo} + {r_hi[SAMPLE_BITS-1], r_hi};

endmodule
